// ===== hw/rtl/ttst_pkg.sv =====
// shared constants, operation codes and cell bus types for the timeout slot table
package ttst_pkg;

    localparam int SLOTS   = 8;
    localparam int KINDS   = 16;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 4;
    localparam int DELAY_W = 32;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET     = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
    localparam logic [OP_W-1:0] OP_RUNNING = 3'd3;
    localparam logic [OP_W-1:0] OP_EXPIRED = 3'd4;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd5;

    typedef struct packed {
        logic               go;
        logic [OP_W-1:0]    op;
        logic [KIND_W-1:0]  kind;
        logic               kind_ok;
        logic [DELAY_W-1:0] delay;
        logic               hit_any;
    } t_cell_cmd;

    typedef struct packed {
        logic hit;
        logic hit_exp;
        logic free;
        logic tick_exp;
    } t_link;

endpackage

// ===== hw/rtl/ttst_if.sv =====
// channel interfaces for items in and results out
interface ttst_in_if;
    import ttst_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [KIND_W-1:0]  timeout_kind;
    logic [DELAY_W-1:0] delay_ticks;

    modport source (output valid, operation, timeout_kind, delay_ticks, input ready);
    modport sink   (input valid, operation, timeout_kind, delay_ticks, output ready);
endinterface

interface ttst_out_if;
    logic valid;
    logic ready;
    logic accepted;
    logic is_running;
    logic is_expired;
    logic expired_now;

    modport source (output valid, accepted, is_running, is_expired, expired_now, input ready);
    modport sink   (input valid, accepted, is_running, is_expired, expired_now, output ready);
endinterface

// ===== hw/rtl/typed_timeout_slot_table.sv =====
// top level: row of timeout slot cells with a registered result stage
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    operation, timeout_kind, delay_ticks
//  o_out    out  valid/ready    accepted, is_running, is_expired, expired_now
//
// one transaction per cycle: every cell updates at the accept edge and the
// result is registered for the next cycle; the hit, free and expiry chains
// across the row of cells set the path length
// a new transaction is taken while the result register is empty or being drained
// synchronous reset frees every slot and empties the result register
module typed_timeout_slot_table
    import ttst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttst_in_if.sink    i_in,
    ttst_out_if.source o_out
);

    t_link     links [SLOTS+1];
    t_cell_cmd cmd;
    logic      take;

    logic r_out_valid;
    logic r_accepted;
    logic r_is_running;
    logic r_is_expired;
    logic r_expired_now;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    assign links[0] = '0;

    assign cmd.go      = take;
    assign cmd.op      = i_in.operation;
    assign cmd.kind    = i_in.timeout_kind;
    assign cmd.kind_ok = (32'(i_in.timeout_kind) < 32'(KINDS));
    assign cmd.delay   = i_in.delay_ticks;
    assign cmd.hit_any = links[SLOTS].hit;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ttst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_link  (links[g]),
            .o_link  (links[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_accepted    <= (i_in.operation == OP_SET) && !links[SLOTS].hit
                             && cmd.kind_ok && links[SLOTS].free;
            r_is_running  <= links[SLOTS].hit;
            r_is_expired  <= (i_in.operation == OP_EXPIRED) && links[SLOTS].hit_exp;
            r_expired_now <= (i_in.operation == OP_TICK) && links[SLOTS].tick_exp;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.accepted    = r_accepted;
    assign o_out.is_running  = r_is_running;
    assign o_out.is_expired  = r_is_expired;
    assign o_out.expired_now = r_expired_now;

endmodule

// ===== hw/rtl/ttst_cell.sv =====
// one timeout slot: kind, countdown and flags, chained to its neighbors
module ttst_cell
    import ttst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_link     i_link,
    output t_link     o_link
);

    logic               r_active;
    logic               r_expd;
    logic [KIND_W-1:0]  r_kind;
    logic [DELAY_W-1:0] r_rem;

    logic               n_active;
    logic               n_expd;
    logic [KIND_W-1:0]  n_kind;
    logic [DELAY_W-1:0] n_rem;

    logic own_hit;
    logic due;
    logic claim;

    assign own_hit = r_active && i_cmd.kind_ok && (r_kind == i_cmd.kind);
    assign due     = r_active && !r_expd && (r_rem <= DELAY_W'(1));
    assign claim   = !r_active && !i_link.free && !i_cmd.hit_any && i_cmd.kind_ok;

    assign o_link.hit      = i_link.hit || own_hit;
    assign o_link.hit_exp  = i_link.hit_exp || (own_hit && r_expd);
    assign o_link.free     = i_link.free || !r_active;
    assign o_link.tick_exp = i_link.tick_exp || due;

    always_comb begin
        n_active = r_active;
        n_expd   = r_expd;
        n_kind   = r_kind;
        n_rem    = r_rem;
        if (i_cmd.go) begin
            unique case (i_cmd.op)
                OP_TICK: begin
                    if (r_active && !r_expd) begin
                        if (due) begin
                            n_rem  = '0;
                            n_expd = 1'b1;
                        end else begin
                            n_rem = r_rem - DELAY_W'(1);
                        end
                    end
                end
                OP_SET: begin
                    if (claim) begin
                        n_active = 1'b1;
                        n_kind   = i_cmd.kind;
                        n_rem    = i_cmd.delay;
                        n_expd   = 1'b0;
                    end
                end
                OP_CLEAR: begin
                    if (own_hit) begin
                        n_active = 1'b0;
                        n_expd   = 1'b0;
                        n_rem    = '0;
                    end
                end
                OP_EXPIRED: begin
                    if (own_hit && r_expd) begin
                        n_active = 1'b0;
                        n_expd   = 1'b0;
                        n_rem    = '0;
                    end
                end
                OP_RESET: begin
                    n_active = 1'b0;
                    n_expd   = 1'b0;
                    n_rem    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_expd   <= 1'b0;
            r_rem    <= '0;
        end else begin
            r_active <= n_active;
            r_expd   <= n_expd;
            r_rem    <= n_rem;
        end
        r_kind <= n_kind;
    end

endmodule
